// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    `ASSERT_PROP(label, clk, rst_n, !(expr))

`endif

// ===== rtl/core/tcsp_pkg.sv =====
// ---------------------------------------------------------------------------
// tcsp_pkg
// Shared types and constants of the threshold-constrained shortest path block.
// ---------------------------------------------------------------------------
package tcsp_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int MAX_EDGES_DEF = 1024;

    localparam int FEE_W     = 31;
    localparam int IDX_W     = 8;
    localparam int NN_W      = 9;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 3;
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 32;

    localparam logic [FEE_W-1:0] FEE_MAX = 31'h7FFF_FFFF;

    // Item function codes
    typedef enum logic [FUNC_W-1:0] {
        FN_SET_FEE  = 2'd0,
        FN_ADD_EDGE = 2'd1,
        FN_RUN      = 2'd2,
        FN_CLEAR    = 2'd3
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_FOUND     = 3'd2,
        STAT_NO_PATH   = 3'd3,
        STAT_BAD_INDEX = 3'd4
    } t_status;

    // Configuration register indexes
    localparam logic CFG_NUM_NODES = 1'b0;
    localparam logic CFG_BUDGET    = 1'b1;

endpackage

// ===== rtl/core/tcsp_ram.sv =====
// ---------------------------------------------------------------------------
// tcsp_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tcsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/threshold_constrained_shortest_path.sv =====
// ---------------------------------------------------------------------------
// threshold_constrained_shortest_path
// Finds the smallest node fee that still allows a path within a cost budget.
// ---------------------------------------------------------------------------
// After reset the block clears its fee memory, one entry a cycle, and takes
// no item meanwhile. The result of a fee, edge or clear item appears in the
// output register on the next cycle. A new item is taken once that register
// is empty, or in the cycle its result is accepted. A run item holds the input
// off until its result is written. It runs one shortest-path trial with every
// node allowed and then up to 31 trials in a bisection over the 31-bit fee
// range. A trial checks the start fee, clears the scratch memory, then for
// each node it settles scans for the minimum, settles the node and reads and
// checks each stored edge. A final scan and a target check end the trial.
// The single ports of the distance and edge memories set these steps.
// ---------------------------------------------------------------------------
module threshold_constrained_shortest_path
    import tcsp_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [FEE_W-1:0]     i_cfg_data,
    // input items
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // node_index[7:0], node_fee[38:8], edge_from[46:39], edge_to[54:47],
    // edge_cost[85:55], zero fill[87:86]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  logic [FUNC_W-1:0]    s_axis_tuser,
    // result items
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // min_max_fee[30:0], zero fill[31]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // status[2:0]
    output logic [STAT_W-1:0]    m_axis_tuser
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int NCW  = ($clog2(MAX_NODES + 1) > NN_W) ? $clog2(MAX_NODES + 1) : NN_W;
    localparam int EAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int DW   = FEE_W + NW + 1;
    localparam int EW   = 2 * IDX_W + FEE_W;
    localparam int XW   = NW + IDX_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_FEE0, S_FEE0_CHK, S_CLR, S_SCAN, S_SETTLE,
        S_E_RD, S_E_CHK, S_E_UPD, S_TGT, S_TGT_CHK
    } t_state;

    t_state             r_state;
    logic [NCW-1:0]     r_cnt;
    logic [NN_W-1:0]    r_num_nodes;
    logic [FEE_W-1:0]   r_budget;
    logic [ECW-1:0]     r_ecount;
    logic [ECW-1:0]     r_e;
    logic               r_full;
    logic [FEE_W-1:0]   r_lim, r_lo, r_hi;
    logic               r_pv, r_found;
    logic [NW-1:0]      r_prev, r_best_u, r_v;
    logic [DW-1:0]      r_best_d;
    logic [FEE_W-1:0]   r_cost;
    logic               r_m_valid;
    t_status            r_m_status;
    logic [FEE_W-1:0]   r_m_fee;

    // input fields
    logic [IDX_W-1:0]   in_idx, in_from, in_to;
    logic [FEE_W-1:0]   in_fee, in_cost;
    t_func              in_func;
    logic               s_accept;

    // node count in use and index helpers
    logic [NCW-1:0]     n_eff, num_ext;
    logic [NW-1:0]      n_last;
    logic [XW-1:0]      idx_x;

    // memory ports
    logic               fee_we;
    logic [NW-1:0]      fee_waddr, fee_raddr;
    logic [FEE_W-1:0]   fee_wdata, fee_q;
    logic               edge_we;
    logic [EW-1:0]      edge_wdata, edge_q;
    logic               dist_we;
    logic [NW-1:0]      dist_waddr, dist_raddr;
    logic [DW+1:0]      dist_wdata, dist_q;

    // read-data views
    logic               q_reached, q_settled;
    logic [DW-1:0]      q_dist;
    logic [IDX_W-1:0]   q_a, q_b;
    logic [FEE_W-1:0]   q_c;
    logic [XW-1:0]      a_x, b_x;
    logic               e_skip;
    logic [NW-1:0]      e_v;
    logic [DW-1:0]      nd;
    logic               upd;
    logic               better;
    logic               ok;
    logic [FEE_W-1:0]   c_lo, c_hi, c_mid;
    logic [FEE_W:0]     mid_sum;
    logic               last_edge;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE) && (!r_m_valid || m_axis_tready);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {1'b0, r_m_fee};

    assign in_func = t_func'(s_axis_tuser);
    assign in_idx  = s_axis_tdata[7:0];
    assign in_fee  = s_axis_tdata[38:8];
    assign in_from = s_axis_tdata[46:39];
    assign in_to   = s_axis_tdata[54:47];
    assign in_cost = s_axis_tdata[85:55];

    // clamp the configured node count into the supported range
    always_comb begin
        num_ext = NCW'(r_num_nodes);
        if (num_ext < NCW'(2)) begin
            n_eff = NCW'(2);
        end else if (num_ext > NCW'(MAX_NODES)) begin
            n_eff = NCW'(MAX_NODES);
        end else begin
            n_eff = num_ext;
        end
    end

    assign n_last = NW'(n_eff - NCW'(1));
    assign idx_x  = XW'(in_idx);

    assign q_reached = dist_q[DW+1];
    assign q_settled = dist_q[DW];
    assign q_dist    = dist_q[DW-1:0];
    assign q_a       = edge_q[IDX_W-1:0];
    assign q_b       = edge_q[2*IDX_W-1:IDX_W];
    assign q_c       = edge_q[EW-1:2*IDX_W];
    assign a_x       = XW'(q_a);
    assign b_x       = XW'(q_b);

    // edge decode: pick the far end of an edge touching the settled node
    always_comb begin
        e_skip = 1'b0;
        e_v    = a_x[NW-1:0];
        if (NCW'(q_a) >= n_eff || NCW'(q_b) >= n_eff) begin
            e_skip = 1'b1;
        end else if (a_x[NW-1:0] == r_best_u) begin
            e_v = b_x[NW-1:0];
        end else if (b_x[NW-1:0] != r_best_u) begin
            e_skip = 1'b1;
        end
    end

    // shared add and relax compare
    assign nd     = r_best_d + DW'(r_cost);
    assign upd    = (fee_q <= r_lim) && (!q_reached || nd < q_dist);
    assign better = q_reached && !q_settled && (!r_found || q_dist < r_best_d);
    assign last_edge = (ECW'(r_e + ECW'(1)) == r_ecount);

    // trial outcome and next bisection bounds
    assign ok = (r_state == S_TGT_CHK) && q_reached && (q_dist <= DW'(r_budget));
    always_comb begin
        if (r_full) begin
            c_lo = '0;
            c_hi = FEE_MAX;
        end else if (ok) begin
            c_lo = r_lo;
            c_hi = r_lim;
        end else begin
            c_lo = FEE_W'(r_lim + FEE_W'(1));
            c_hi = r_hi;
        end
        mid_sum = (FEE_W + 1)'(c_lo) + (FEE_W + 1)'(c_hi);
        c_mid   = mid_sum[FEE_W:1];
    end

    // memory port control
    always_comb begin
        fee_we     = 1'b0;
        fee_waddr  = r_cnt[NW-1:0];
        fee_wdata  = '0;
        fee_raddr  = '0;
        edge_we    = 1'b0;
        edge_wdata = {in_cost, in_to, in_from};
        dist_we    = 1'b0;
        dist_waddr = r_cnt[NW-1:0];
        dist_wdata = '0;
        dist_raddr = r_cnt[NW-1:0];
        unique case (r_state)
            S_INIT: begin
                fee_we = 1'b1;
            end
            S_IDLE: begin
                if (s_accept && in_func == FN_SET_FEE && NCW'(in_idx) < n_eff) begin
                    fee_we    = 1'b1;
                    fee_waddr = idx_x[NW-1:0];
                    fee_wdata = in_fee;
                end
                if (s_accept && in_func == FN_ADD_EDGE && NCW'(in_from) < n_eff &&
                    NCW'(in_to) < n_eff && r_ecount < ECW'(MAX_EDGES)) begin
                    edge_we = 1'b1;
                end
            end
            S_CLR: begin
                dist_we    = 1'b1;
                dist_wdata = {(r_cnt == '0), 1'b0, DW'(0)};
            end
            S_SETTLE: begin
                dist_we    = 1'b1;
                dist_waddr = r_best_u;
                dist_wdata = {1'b1, 1'b1, r_best_d};
            end
            S_E_CHK: begin
                fee_raddr  = e_v;
                dist_raddr = e_v;
            end
            S_E_UPD: begin
                dist_we    = upd;
                dist_waddr = r_v;
                dist_wdata = {1'b1, q_settled, nd};
            end
            S_TGT: begin
                dist_raddr = n_last;
            end
            default: begin
            end
        endcase
    end

    // sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_num_nodes <= NN_W'(2);
            r_budget    <= '0;
            r_ecount    <= '0;
            r_m_valid   <= 1'b0;
            r_full      <= 1'b0;
            r_pv        <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NUM_NODES) begin
                    r_num_nodes <= i_cfg_data[NN_W-1:0];
                end else begin
                    r_budget <= i_cfg_data;
                end
            end

            if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_INIT: begin
                    r_cnt <= NCW'(r_cnt + NCW'(1));
                    if (r_cnt == NCW'(MAX_NODES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        r_m_fee    <= '0;
                        r_m_status <= STAT_OK;
                        unique case (in_func)
                            FN_SET_FEE: begin
                                r_m_valid <= 1'b1;
                                if (NCW'(in_idx) >= n_eff) begin
                                    r_m_status <= STAT_BAD_INDEX;
                                end
                            end
                            FN_ADD_EDGE: begin
                                r_m_valid <= 1'b1;
                                if (NCW'(in_from) >= n_eff || NCW'(in_to) >= n_eff) begin
                                    r_m_status <= STAT_BAD_INDEX;
                                end else if (r_ecount >= ECW'(MAX_EDGES)) begin
                                    r_m_status <= STAT_FULL;
                                end else begin
                                    r_ecount <= ECW'(r_ecount + ECW'(1));
                                end
                            end
                            FN_RUN: begin
                                r_full  <= 1'b1;
                                r_lim   <= FEE_MAX;
                                r_state <= S_FEE0;
                            end
                            FN_CLEAR: begin
                                r_m_valid <= 1'b1;
                                r_ecount  <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_FEE0: begin
                    r_state <= S_FEE0_CHK;
                end
                S_FEE0_CHK: begin
                    r_cnt <= '0;
                    if (fee_q > r_lim) begin
                        // start node over the limit: trial fails
                        if (r_full) begin
                            r_m_valid  <= 1'b1;
                            r_m_status <= STAT_NO_PATH;
                            r_state    <= S_IDLE;
                        end else begin
                            r_lo <= c_lo;
                            r_hi <= c_hi;
                            if (c_lo < c_hi) begin
                                r_lim   <= c_mid;
                                r_state <= S_FEE0;
                            end else begin
                                r_m_valid  <= 1'b1;
                                r_m_status <= STAT_FOUND;
                                r_m_fee    <= c_lo;
                                r_state    <= S_IDLE;
                            end
                        end
                    end else begin
                        r_state <= S_CLR;
                    end
                end
                S_CLR: begin
                    r_cnt <= NCW'(r_cnt + NCW'(1));
                    if (r_cnt == NCW'(n_eff - NCW'(1))) begin
                        r_cnt   <= '0;
                        r_pv    <= 1'b0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // evaluate the entry read last cycle
                    if (r_pv && better) begin
                        r_found  <= 1'b1;
                        r_best_u <= r_prev;
                        r_best_d <= q_dist;
                    end
                    if (r_cnt < n_eff) begin
                        r_prev <= r_cnt[NW-1:0];
                        r_pv   <= 1'b1;
                        r_cnt  <= NCW'(r_cnt + NCW'(1));
                    end else if (r_pv) begin
                        r_pv <= 1'b0;
                    end else begin
                        r_state <= r_found ? S_SETTLE : S_TGT;
                    end
                end
                S_SETTLE: begin
                    r_e <= '0;
                    if (r_ecount == '0) begin
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_CHK;
                end
                S_E_CHK: begin
                    r_v    <= e_v;
                    r_cost <= q_c;
                    if (!e_skip) begin
                        r_state <= S_E_UPD;
                    end else begin
                        r_e <= ECW'(r_e + ECW'(1));
                        if (last_edge) begin
                            r_cnt   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_E_RD;
                        end
                    end
                end
                S_E_UPD: begin
                    r_e <= ECW'(r_e + ECW'(1));
                    if (last_edge) begin
                        r_cnt   <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_E_RD;
                    end
                end
                S_TGT: begin
                    r_state <= S_TGT_CHK;
                end
                S_TGT_CHK: begin
                    r_full <= 1'b0;
                    if (r_full && !ok) begin
                        r_m_valid  <= 1'b1;
                        r_m_status <= STAT_NO_PATH;
                        r_state    <= S_IDLE;
                    end else begin
                        r_lo <= c_lo;
                        r_hi <= c_hi;
                        if (c_lo < c_hi) begin
                            r_lim   <= c_mid;
                            r_state <= S_FEE0;
                        end else begin
                            r_m_valid  <= 1'b1;
                            r_m_status <= STAT_FOUND;
                            r_m_fee    <= c_lo;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // per-node fee
    tcsp_ram #(.WIDTH(FEE_W), .DEPTH(MAX_NODES), .AW(NW)) u_fee_ram (
        .i_clk   (i_clk),
        .i_we    (fee_we),
        .i_waddr (fee_waddr),
        .i_wdata (fee_wdata),
        .i_raddr (fee_raddr),
        .o_rdata (fee_q)
    );

    // edge store: {cost, end b, end a}
    tcsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES), .AW(EAW)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_ecount[EAW-1:0]),
        .i_wdata (edge_wdata),
        .i_raddr (r_e[EAW-1:0]),
        .o_rdata (edge_q)
    );

    // trial scratch: {reached, settled, distance}
    tcsp_ram #(.WIDTH(DW + 2), .DEPTH(MAX_NODES), .AW(NW)) u_dist_ram (
        .i_clk   (i_clk),
        .i_we    (dist_we),
        .i_waddr (dist_waddr),
        .i_wdata (dist_wdata),
        .i_raddr (dist_raddr),
        .o_rdata (dist_q)
    );

endmodule

// ===== rtl/core/tcsp_checker.sv =====
// ---------------------------------------------------------------------------
// tcsp_checker
// Port-level checks of the threshold-constrained shortest path block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tcsp_checker
    import tcsp_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready,
    input logic                 i_cfg_index,
    input logic [FEE_W-1:0]     i_cfg_data,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic [S_TDATA_W-1:0] s_axis_tdata,
    input logic [FUNC_W-1:0]    s_axis_tuser,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [STAT_W-1:0]    m_axis_tuser
);

    logic                        out_stall;
    logic [M_TDATA_W+STAT_W-1:0] out_word;
    logic                        stray_fee;
    logic                        in_run;
    logic                        in_load;
    logic                        load_ok;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};
    assign stray_fee = m_axis_tvalid && m_axis_tuser != STAT_FOUND && m_axis_tdata != '0;
    assign in_run    = s_axis_tvalid && s_axis_tready && s_axis_tuser == FN_RUN;
    assign in_load   = s_axis_tvalid && s_axis_tready && s_axis_tuser != FN_RUN;
    assign load_ok   = m_axis_tvalid && m_axis_tuser != STAT_FOUND &&
                       m_axis_tuser != STAT_NO_PATH;

    // stalled result holds
    `ASSERT_PROP(a_out_hold, i_clk, i_rst_n, out_stall |=> m_axis_tvalid && $stable(out_word))

    // only a found path carries a fee
    `ASSERT_NEVER(a_fee_zero, i_clk, i_rst_n, stray_fee)

    // a run transaction blocks the input next cycle
    `ASSERT_PROP(a_run_busy, i_clk, i_rst_n, in_run |=> !s_axis_tready)

    // a load transaction yields a result on the next cycle
    `ASSERT_PROP(a_load_result, i_clk, i_rst_n, in_load |=> load_ok)

endmodule

bind threshold_constrained_shortest_path tcsp_checker u_tcsp_checker (.*);

// ===== sim/tcsp_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tcsp_scoreboard
// Watches the config, item and result channels of the path search block,
// predicts each result from its own copy of fees, edges and registers, and
// compares every result transaction field by field in order.
// ---------------------------------------------------------------------------
module tcsp_scoreboard
    import tcsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [FEE_W-1:0]     i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    input  logic [FUNC_W-1:0]    i_s_tuser,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,
    input  logic [STAT_W-1:0]    i_m_tuser,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_found
);

    typedef struct packed {
        t_status          status;
        logic [FEE_W-1:0] fee;
    } t_result;

    localparam int NODES = MAX_NODES_DEF;
    localparam int EDGES = MAX_EDGES_DEF;

    // Predictor state
    logic [NN_W-1:0]  node_count_reg;
    logic [FEE_W-1:0] budget_reg;
    logic [FEE_W-1:0] fee_mem [NODES];
    logic [IDX_W-1:0] end_a [EDGES];
    logic [IDX_W-1:0] end_b [EDGES];
    logic [FEE_W-1:0] cost_mem [EDGES];
    int               stored_edges;
    t_result          expected_results [$];

    assign o_pending = expected_results.size();

    function automatic int active_nodes();
        int n;
        n = node_count_reg;
        if (n < 2) n = 2;
        if (n > NODES) n = NODES;
        return n;
    endfunction

    // One Dijkstra trial: is the last node reachable within budget using only
    // nodes whose fee is at most limit
    function automatic bit reachable_within(logic [FEE_W-1:0] limit, int n);
        bit              done_node [NODES];
        bit              seen [NODES];
        longint unsigned node_dist [NODES];
        longint unsigned nd;
        int              u;
        int              v;
        if (fee_mem[0] > limit) return 1'b0;
        for (int i = 0; i < NODES; i++) begin
            done_node[i] = 1'b0;
            seen[i] = 1'b0;
            node_dist[i] = 0;
        end
        seen[0] = 1'b1;
        while (1) begin
            u = n;
            for (int i = 0; i < n; i++)
                if (seen[i] && !done_node[i] && (u == n || node_dist[i] < node_dist[u]))
                    u = i;
            if (u == n) break;
            done_node[u] = 1'b1;
            for (int e = 0; e < stored_edges; e++) begin
                if (end_a[e] >= n || end_b[e] >= n) continue;
                if (end_a[e] == u) v = end_b[e];
                else if (end_b[e] == u) v = end_a[e];
                else continue;
                if (fee_mem[v] > limit) continue;
                nd = node_dist[u] + longint'(cost_mem[e]);
                if (!seen[v] || nd < node_dist[v]) begin
                    seen[v] = 1'b1;
                    node_dist[v] = nd;
                end
            end
        end
        return seen[n-1] && node_dist[n-1] <= longint'(budget_reg);
    endfunction

    // Smallest feasible fee threshold, bisection over sorted fees
    function automatic t_result search_threshold();
        t_result          r;
        logic [FEE_W-1:0] sorted [NODES];
        logic [FEE_W-1:0] key;
        int               n;
        int               j;
        int               lo;
        int               hi;
        int               mid;
        n = active_nodes();
        r.fee = '0;
        if (!reachable_within(FEE_MAX, n)) begin
            r.status = STAT_NO_PATH;
            return r;
        end
        for (int i = 0; i < n; i++) sorted[i] = fee_mem[i];
        for (int i = 1; i < n; i++) begin
            key = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > key) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = key;
        end
        lo = 0;
        hi = n - 1;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (reachable_within(sorted[mid], n)) hi = mid;
            else lo = mid + 1;
        end
        r.status = STAT_FOUND;
        r.fee = sorted[lo];
        return r;
    endfunction

    function automatic t_result apply_item(t_func fn, logic [S_TDATA_W-1:0] d);
        t_result          r;
        logic [IDX_W-1:0] idx;
        logic [FEE_W-1:0] fee;
        logic [IDX_W-1:0] ea;
        logic [IDX_W-1:0] eb;
        logic [FEE_W-1:0] ec;
        int               n;
        idx = d[7:0];
        fee = d[38:8];
        ea  = d[46:39];
        eb  = d[54:47];
        ec  = d[85:55];
        n   = active_nodes();
        r.status = STAT_OK;
        r.fee = '0;
        case (fn)
            FN_SET_FEE: begin
                if (idx >= n) r.status = STAT_BAD_INDEX;
                else fee_mem[idx] = fee;
            end
            FN_ADD_EDGE: begin
                if (ea >= n || eb >= n) r.status = STAT_BAD_INDEX;
                else if (stored_edges >= EDGES) r.status = STAT_FULL;
                else begin
                    end_a[stored_edges] = ea;
                    end_b[stored_edges] = eb;
                    cost_mem[stored_edges] = ec;
                    stored_edges++;
                end
            end
            FN_RUN: r = search_threshold();
            default: stored_edges = 0;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Checks finish before the new item is predicted, so a result never meets
    // the expectation of an item taken in the same cycle
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            node_count_reg = 2;
            budget_reg = '0;
            stored_edges = 0;
            for (int i = 0; i < NODES; i++) fee_mem[i] = '0;
            expected_results.delete();
            o_fail_count = 0;
            o_checked = 0;
            o_found = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, status", i_m_tuser, -1);
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_tuser != want.status)
                        report_mismatch("status", i_m_tuser, want.status);
                    if (i_m_tdata != {1'b0, want.fee})
                        report_mismatch("min_max_fee", i_m_tdata, want.fee);
                    if (want.status == STAT_FOUND) o_found++;
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_NUM_NODES) node_count_reg = i_cfg_data[NN_W-1:0];
                else budget_reg = i_cfg_data;
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(apply_item(t_func'(i_s_tuser), i_s_tdata));
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the threshold-constrained shortest path block: directed corner
// cases, then random small graphs under rotating idle and stall patterns.
// ---------------------------------------------------------------------------
module tb;
    import tcsp_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     RAND_GRAPHS = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = 1'b0;
    logic [FEE_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [FUNC_W-1:0]    s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [STAT_W-1:0]    m_axis_tuser;

    int     fail_count;
    int     pending;
    int     checked;
    int     found;
    int     items_sent = 0;
    int     tx_idle_pct = 0;
    int     rx_stall_pct = 0;
    int     rx_hold = 0;
    longint cycles = 0;
    int     cur_nodes;

    threshold_constrained_shortest_path u_dut (.*);

    tcsp_scoreboard u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_found     (found)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: long hold-off when requested, else random stalls
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Leaves tvalid high after the transaction; the caller either sends again
    // in the same step or lowers it
    task automatic send_item(t_func fn, logic [IDX_W-1:0] idx, logic [FEE_W-1:0] fee,
                             logic [IDX_W-1:0] ea, logic [IDX_W-1:0] eb,
                             logic [FEE_W-1:0] ec);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {2'b00, ec, eb, ea, fee, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic set_fee(int idx, logic [FEE_W-1:0] fee);
        send_item(FN_SET_FEE, IDX_W'(idx), fee, IDX_W'($urandom), IDX_W'($urandom),
                  FEE_W'($urandom));
    endtask

    task automatic add_edge(int a, int b, logic [FEE_W-1:0] c);
        send_item(FN_ADD_EDGE, IDX_W'($urandom), FEE_W'($urandom), IDX_W'(a), IDX_W'(b), c);
    endtask

    task automatic run_search();
        send_item(FN_RUN, IDX_W'($urandom), FEE_W'($urandom), IDX_W'($urandom),
                  IDX_W'($urandom), FEE_W'($urandom));
    endtask

    task automatic clear_edges();
        send_item(FN_CLEAR, IDX_W'($urandom), FEE_W'($urandom), IDX_W'($urandom),
                  IDX_W'($urandom), FEE_W'($urandom));
    endtask

    // Sender pauses until every expected result has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [FEE_W-1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_NUM_NODES) begin
            cur_nodes = (val < 2) ? 2 : (val > MAX_NODES_DEF) ? MAX_NODES_DEF : int'(val);
        end
    endtask

    function automatic logic [FEE_W-1:0] pick_fee();
        case ($urandom_range(9))
            0:       return '0;
            1:       return FEE_MAX;
            2, 3:    return FEE_W'($urandom);
            default: return FEE_W'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [FEE_W-1:0] pick_cost();
        case ($urandom_range(11))
            0:       return FEE_W'($urandom);
            1:       return FEE_MAX;
            default: return FEE_W'($urandom_range(10));
        endcase
    endfunction

    function automatic logic [FEE_W-1:0] pick_budget();
        case ($urandom_range(5))
            0:       return '0;
            1:       return FEE_MAX;
            2:       return FEE_W'($urandom);
            default: return FEE_W'($urandom_range(30));
        endcase
    endfunction

    // One random graph: registers, fees, edges, then one to three searches
    task automatic random_graph(int scen);
        int n;
        int ne;
        int a;
        int b;
        case (scen % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 67; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 67; end
            default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
        endcase
        n = ($urandom_range(7) == 0) ? $urandom_range(9, 12) : $urandom_range(2, 8);
        if ($urandom_range(15) == 0) n = $urandom_range(1);  // clamped to two
        write_reg(CFG_NUM_NODES, FEE_W'(n));
        write_reg(CFG_BUDGET, pick_budget());
        clear_edges();
        for (int i = 0; i < cur_nodes; i++) set_fee(i, pick_fee());
        ne = $urandom_range(0, 2 * cur_nodes);
        for (int i = 0; i < ne; i++) begin
            a = $urandom_range(cur_nodes - 1);
            b = $urandom_range(cur_nodes - 1);
            if ($urandom_range(11) == 0) a = $urandom_range(255);
            if ($urandom_range(11) == 0) b = $urandom_range(255);
            add_edge(a, b, pick_cost());
            // random noise: stray fee writes, bad indexes, extra searches
            if ($urandom_range(7) == 0)
                send_item(t_func'($urandom_range(2)), IDX_W'($urandom), FEE_W'($urandom),
                          IDX_W'($urandom), IDX_W'($urandom), FEE_W'($urandom));
        end
        run_search();
        if ($urandom_range(2) == 0) begin
            write_reg(CFG_BUDGET, pick_budget());
            run_search();
        end
        if ($urandom_range(5) == 0) begin
            write_reg(CFG_NUM_NODES, FEE_W'($urandom_range(2, cur_nodes)));
            run_search();
        end
    endtask

    initial begin
        int scen;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cur_nodes = 2;

        // Directed: reset defaults, two nodes, no edges
        run_search();
        add_edge(0, 1, 0);
        run_search();
        set_fee(0, FEE_MAX);        // start fee gates every lower threshold
        set_fee(1, 0);
        run_search();
        set_fee(255, 5);            // fee index beyond nodes in use
        add_edge(0, 200, 1);        // edge end beyond nodes in use
        add_edge(1, 1, 3);          // self-loop
        write_reg(CFG_NUM_NODES, 3);
        write_reg(CFG_BUDGET, FEE_MAX);
        set_fee(0, 1);
        set_fee(2, 7);
        add_edge(0, 2, FEE_MAX);
        add_edge(2, 1, FEE_MAX);
        run_search();
        write_reg(CFG_NUM_NODES, 2); // edges to node 2 now skipped
        run_search();
        write_reg(CFG_NUM_NODES, 0);
        write_reg(CFG_BUDGET, 0);
        run_search();
        write_reg(CFG_NUM_NODES, 511); // clamped to the node limit
        add_edge(0, 255, 4);
        add_edge(255, 128, 0);
        set_fee(255, 9);
        run_search();
        write_reg(CFG_BUDGET, 4);
        run_search();

        // Fill the edge store, then one more edge and one bad one
        write_reg(CFG_NUM_NODES, 2);
        clear_edges();
        for (int i = 0; i < MAX_EDGES_DEF; i++) add_edge(i % 2, 1, FEE_W'(i));
        add_edge(0, 1, 1);
        add_edge(0, 9, 1);
        clear_edges();

        // Result side holds off while items keep coming
        drain();
        rx_hold = 400;
        for (int i = 0; i < 40; i++) set_fee($urandom_range(1), FEE_W'($urandom));

        // Random graphs, each idle pattern twice
        scen = 0;
        while (scen < RAND_GRAPHS) begin
            random_graph(scen);
            scen++;
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d items: directed cases, a full edge store, a long result stall",
                 items_sent);
        $display("and %0d random graphs; %0d results checked, %0d paths found",
                 scen, checked, found);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
